>>> hw/rtl/frustum_cull_sphere_box_macros.svh
// ----------------------------------------------------------------------------
// frustum_cull_sphere_box assertion macros
// Shared concurrent assertion forms for the frustum culling block.
// ----------------------------------------------------------------------------
`ifndef FRUSTUM_CULL_SPHERE_BOX_MACROS_SVH
`define FRUSTUM_CULL_SPHERE_BOX_MACROS_SVH

// same-cycle implication, off while reset is asserted
`define FCSB_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("frustum cull assertion failed");

// delayed implication, off while reset is asserted
`define FCSB_ASSERT_LAT3(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> ##3 (cons)) \
        else $error("frustum cull latency assertion failed");

// next-cycle implication, always active (used for reset behavior)
`define FCSB_ASSERT_NEXT(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("frustum cull reset assertion failed");

`endif

>>> hw/rtl/fcsb_pkg.sv
// ----------------------------------------------------------------------------
// fcsb_pkg
// Types, constants and helpers for the frustum sphere/box culling block.
// ----------------------------------------------------------------------------
package fcsb_pkg;

    localparam int COORD_BITS  = 16;
    localparam int NORM_BITS   = 16;
    localparam int FRAC_SHIFT  = 14;
    localparam int NUM_PLANES  = 6;
    localparam int NUM_AXES    = 3;
    localparam int CFG_DATA_W  = 64;
    localparam int CFG_IDX_W   = 3;
    localparam int AXIS_W      = 2;
    localparam int PROD_W      = COORD_BITS + NORM_BITS;
    localparam int DTERM_W     = NORM_BITS + FRAC_SHIFT;
    localparam int SUM_W       = ((PROD_W > DTERM_W) ? PROD_W : DTERM_W) + 2;

    localparam logic OP_SPHERE = 1'b0;
    localparam logic OP_BOX    = 1'b1;

    typedef enum logic [1:0] {
        REL_OUTSIDE   = 2'd0,
        REL_INTERSECT = 2'd1,
        REL_INSIDE    = 2'd2
    } t_rel;

    localparam logic [AXIS_W-1:0] AXIS_X = 2'd0;
    localparam logic [AXIS_W-1:0] AXIS_Y = 2'd1;
    localparam logic [AXIS_W-1:0] AXIS_Z = 2'd2;

    // one plane register: d in the top word, nx in the bottom word
    typedef struct packed {
        logic signed [NORM_BITS-1:0] d;
        logic signed [NORM_BITS-1:0] nz;
        logic signed [NORM_BITS-1:0] ny;
        logic signed [NORM_BITS-1:0] nx;
    } t_plane;

    function automatic logic signed [NORM_BITS-1:0] f_norm(input t_plane p,
                                                           input logic [AXIS_W-1:0] axis);
        logic signed [NORM_BITS-1:0] n;
        unique case (axis)
            AXIS_X:  n = p.nx;
            AXIS_Y:  n = p.ny;
            AXIS_Z:  n = p.nz;
            default: n = '0;
        endcase
        return n;
    endfunction

    // plane offset lined up with the 14 fraction bits of the products
    function automatic logic signed [SUM_W-1:0] f_dterm(input t_plane p);
        logic signed [SUM_W-1:0] dext;
        dext = SUM_W'(p.d);
        return dext <<< FRAC_SHIFT;
    endfunction

endpackage

>>> hw/rtl/frustum_cull_sphere_box.sv
`include "frustum_cull_sphere_box_macros.svh"
// ----------------------------------------------------------------------------
// frustum_cull_sphere_box
// Sphere / axis-aligned box classification against six frustum planes.
// ----------------------------------------------------------------------------
// Usage:
//   Planes are loaded through i_cfg_we / i_cfg_idx / i_cfg_data, index 0..5
//   (left, right, bottom, top, near, far); higher indexes are ignored. Load
//   them only while no word is in flight.
//   A word is taken on each rising edge with i_start high and o_busy low;
//   o_busy stays low, so one word is taken every cycle.
//   i_operation selects the sphere test (center ax/ay/az, i_radius) or the
//   box test (corners ax/ay/az and bx/by_max/bz, either order per axis).
//   The result shows on o_relation with o_valid for one cycle, once the word
//   has passed the input register (loaded at the accepting edge) and then
//   the product, per-axis select and result registers. Throughput is one
//   word per cycle: every stage, including the 36 parallel 16x16 multipliers
//   of the product stage, takes a new word each cycle.
//   The receiver cannot stall; every result must be taken when o_valid is high.
//   Synchronous reset clears the pipeline valids and all six planes to zero;
//   with zero planes a box reads inside and a sphere with radius intersecting.
// ----------------------------------------------------------------------------
module frustum_cull_sphere_box (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_start,
    output logic                                    o_busy,
    input  logic                                    i_operation,
    input  logic signed [fcsb_pkg::COORD_BITS-1:0]  i_ax,
    input  logic signed [fcsb_pkg::COORD_BITS-1:0]  i_ay,
    input  logic signed [fcsb_pkg::COORD_BITS-1:0]  i_az,
    input  logic signed [fcsb_pkg::COORD_BITS-1:0]  i_bx,
    input  logic signed [fcsb_pkg::COORD_BITS-1:0]  i_by_max,
    input  logic signed [fcsb_pkg::COORD_BITS-1:0]  i_bz,
    input  logic        [fcsb_pkg::COORD_BITS-2:0]  i_radius,
    input  logic                                    i_cfg_we,
    input  logic        [fcsb_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic        [fcsb_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output logic                                    o_valid,
    output logic        [1:0]                       o_relation
);
    import fcsb_pkg::*;

    t_plane r_plane [NUM_PLANES];

    // stage 0: input register
    logic                          r_s0_vld;
    logic                          r_s0_op;
    logic signed [COORD_BITS-1:0]  r_s0_a [NUM_AXES];
    logic signed [COORD_BITS-1:0]  r_s0_b [NUM_AXES];
    logic        [COORD_BITS-2:0]  r_s0_rad;

    // stage 1: products
    logic                          r_s1_vld;
    logic                          r_s1_op;
    logic        [COORD_BITS-2:0]  r_s1_rad;
    logic signed [PROD_W-1:0]      r_s1_plo [NUM_PLANES][NUM_AXES];
    logic signed [PROD_W-1:0]      r_s1_phi [NUM_PLANES][NUM_AXES];
    logic signed [PROD_W-1:0]      n_s1_plo [NUM_PLANES][NUM_AXES];
    logic signed [PROD_W-1:0]      n_s1_phi [NUM_PLANES][NUM_AXES];

    // stage 2: per-axis extremes and sphere distances
    logic                          r_s2_vld;
    logic                          r_s2_op;
    logic        [COORD_BITS-2:0]  r_s2_rad;
    logic signed [PROD_W-1:0]      r_s2_mx [NUM_PLANES][NUM_AXES];
    logic signed [PROD_W-1:0]      r_s2_mn [NUM_PLANES][NUM_AXES];
    logic signed [SUM_W-1:0]       r_s2_sd [NUM_PLANES];
    logic signed [PROD_W-1:0]      n_s2_mx [NUM_PLANES][NUM_AXES];
    logic signed [PROD_W-1:0]      n_s2_mn [NUM_PLANES][NUM_AXES];
    logic signed [SUM_W-1:0]       n_s2_sd [NUM_PLANES];

    // stage 3: classification
    logic                          r_out_vld;
    t_rel                          r_rel;
    t_rel                          n_rel;

    logic                          w_accept;
    logic signed [SUM_W-1:0]       w_rad;
    logic signed [SUM_W-1:0]       w_maxsum [NUM_PLANES];
    logic signed [SUM_W-1:0]       w_minsum [NUM_PLANES];
    logic        [NUM_PLANES-1:0]  w_sph_out;
    logic        [NUM_PLANES-1:0]  w_sph_cut;
    logic        [NUM_PLANES-1:0]  w_box_out;
    logic        [NUM_PLANES-1:0]  w_box_in;
    logic                          w_mxmn_ok;

    assign o_busy   = 1'b0;
    assign w_accept = i_start && !o_busy;

    // plane registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_PLANES; k++) begin
                r_plane[k] <= '0;
            end
        end else if (i_cfg_we && (i_cfg_idx < CFG_IDX_W'(NUM_PLANES))) begin
            r_plane[i_cfg_idx] <= t_plane'(i_cfg_data);
        end
    end

    // valid pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_vld  <= 1'b0;
            r_s1_vld  <= 1'b0;
            r_s2_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_s0_vld  <= w_accept;
            r_s1_vld  <= r_s0_vld;
            r_s2_vld  <= r_s1_vld;
            r_out_vld <= r_s2_vld;
        end
    end

    // stage 1 products: normal component times each corner coordinate
    always_comb begin
        for (int k = 0; k < NUM_PLANES; k++) begin
            for (int j = 0; j < NUM_AXES; j++) begin
                n_s1_plo[k][j] = PROD_W'(f_norm(r_plane[k], AXIS_W'(j))) * PROD_W'(r_s0_a[j]);
                n_s1_phi[k][j] = PROD_W'(f_norm(r_plane[k], AXIS_W'(j))) * PROD_W'(r_s0_b[j]);
            end
        end
    end

    // stage 2: the extreme corner per plane is the per-axis extreme product
    always_comb begin
        for (int k = 0; k < NUM_PLANES; k++) begin
            for (int j = 0; j < NUM_AXES; j++) begin
                if (r_s1_plo[k][j] > r_s1_phi[k][j]) begin
                    n_s2_mx[k][j] = r_s1_plo[k][j];
                    n_s2_mn[k][j] = r_s1_phi[k][j];
                end else begin
                    n_s2_mx[k][j] = r_s1_phi[k][j];
                    n_s2_mn[k][j] = r_s1_plo[k][j];
                end
            end
            n_s2_sd[k] = SUM_W'(r_s1_plo[k][0]) + SUM_W'(r_s1_plo[k][1])
                       + SUM_W'(r_s1_plo[k][2]) + f_dterm(r_plane[k]);
        end
    end

    // stage 3: plane tests and final relation
    always_comb begin
        w_rad = $signed(SUM_W'(r_s2_rad)) <<< FRAC_SHIFT;
        for (int k = 0; k < NUM_PLANES; k++) begin
            w_maxsum[k]  = SUM_W'(r_s2_mx[k][0]) + SUM_W'(r_s2_mx[k][1])
                         + SUM_W'(r_s2_mx[k][2]) + f_dterm(r_plane[k]);
            w_minsum[k]  = SUM_W'(r_s2_mn[k][0]) + SUM_W'(r_s2_mn[k][1])
                         + SUM_W'(r_s2_mn[k][2]) + f_dterm(r_plane[k]);
            w_sph_out[k] = (r_s2_sd[k] <= -w_rad);
            // once no plane rejects, a cut needs only the upper bound
            w_sph_cut[k] = (r_s2_sd[k] < w_rad);
            w_box_out[k] = w_maxsum[k][SUM_W-1];
            w_box_in[k]  = !w_minsum[k][SUM_W-1];
        end

        if (r_s2_op == OP_BOX) begin
            if (|w_box_out) begin
                n_rel = REL_OUTSIDE;
            end else if (&w_box_in) begin
                n_rel = REL_INSIDE;
            end else begin
                n_rel = REL_INTERSECT;
            end
        end else begin
            if (|w_sph_out) begin
                n_rel = REL_OUTSIDE;
            end else if (|w_sph_cut) begin
                n_rel = REL_INTERSECT;
            end else begin
                n_rel = REL_INSIDE;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_s0_op  <= i_operation;
        r_s0_a[0] <= i_ax;
        r_s0_a[1] <= i_ay;
        r_s0_a[2] <= i_az;
        r_s0_b[0] <= i_bx;
        r_s0_b[1] <= i_by_max;
        r_s0_b[2] <= i_bz;
        r_s0_rad <= i_radius;

        r_s1_op  <= r_s0_op;
        r_s1_rad <= r_s0_rad;
        r_s1_plo <= n_s1_plo;
        r_s1_phi <= n_s1_phi;

        r_s2_op  <= r_s1_op;
        r_s2_rad <= r_s1_rad;
        r_s2_mx  <= n_s2_mx;
        r_s2_mn  <= n_s2_mn;
        r_s2_sd  <= n_s2_sd;

        r_rel    <= n_rel;
    end

    assign o_valid    = r_out_vld;
    assign o_relation = r_rel;

    always_comb begin
        w_mxmn_ok = 1'b1;
        for (int k = 0; k < NUM_PLANES; k++) begin
            for (int j = 0; j < NUM_AXES; j++) begin
                if (r_s2_mx[k][j] < r_s2_mn[k][j]) begin
                    w_mxmn_ok = 1'b0;
                end
            end
        end
    end

    `FCSB_ASSERT_LAT3(a_latency, i_clk, i_rst_n, r_s0_vld, o_valid)
    `FCSB_ASSERT_IMPL(a_extreme_order, i_clk, i_rst_n, r_s2_vld, w_mxmn_ok)
    `FCSB_ASSERT_NEXT(a_reset_clears, i_clk, !i_rst_n, !o_valid && !r_s0_vld)

endmodule
